// ----- src/assert_macros.svh -----
// Assertion helpers shared by the range minimum tree modules.
// Simulation builds get concurrent assertions; synthesis builds define SYNTH
// and the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`else
`define ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ----- src/rmt_pkg.sv -----
`timescale 1ns / 1ps
package rmt_pkg;

	// Widths of the request and result fields.
	localparam int IDX_W  = 10;
	localparam int DATA_W = 32;

	// Request function codes.
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic ld_wr;    // load cursor and accumulator for a leaf write
		logic ld_qry;   // load range bounds and set the accumulator to infinity
		logic clr_wr;   // write infinity at the clear counter, then advance it
		logic leaf_wr;  // write the accumulator at the leaf
		logic sib_rd;   // read the sibling of the cursor node
		logic par_wr;   // write the merged minimum into the parent
		logic l_rd;     // read the left bound node and advance it
		logic r_rd;     // read the node just left of the right bound
		logic shift;    // move both bounds up one level
	} rmt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic wr_oob;    // requested leaf is past the last leaf
		logic clr_last;  // clear counter sits on the last node
		logic par_root;  // the parent of the cursor is the root
		logic l_lt_r;    // query bounds still enclose nodes
		logic l_odd;     // left bound is a right child
		logic r_odd;     // right bound is a right child
	} rmt_sts_t;

endpackage

// ----- src/rmt_ram.sv -----
`timescale 1ns / 1ps
module rmt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/rmt_ctrl.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rmt_ctrl
	import rmt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     func,
	input  rmt_sts_t sts,
	output rmt_cmd_t cmd,
	output logic     busy,
	output logic     done
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_W_LEAF,
		ST_W_READ,
		ST_W_MERGE,
		ST_Q_LEFT,
		ST_Q_RIGHT
	} state_t;

	state_t state_q, state_d;
	logic   done_q, done_d;
	logic   accept;

	assign accept = (state_q == ST_IDLE) && start;

	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (func == FUNC_QUERY) begin
						cmd.ld_qry = 1'b1;
						state_d    = ST_Q_LEFT;
					end else if (!sts.wr_oob) begin
						cmd.ld_wr = 1'b1;
						state_d   = ST_W_LEAF;
					end
				end
			end
			ST_W_LEAF: begin
				cmd.leaf_wr = 1'b1;
				state_d     = ST_W_READ;
			end
			ST_W_READ: begin
				cmd.sib_rd = 1'b1;
				state_d    = ST_W_MERGE;
			end
			ST_W_MERGE: begin
				cmd.par_wr = 1'b1;
				cmd.shift  = 1'b1;
				state_d    = sts.par_root ? ST_IDLE : ST_W_READ;
			end
			ST_Q_LEFT: begin
				if (!sts.l_lt_r) begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.l_rd = sts.l_odd;
					state_d  = ST_Q_RIGHT;
				end
			end
			ST_Q_RIGHT: begin
				cmd.r_rd  = sts.r_odd;
				cmd.shift = 1'b1;
				state_d   = ST_Q_LEFT;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	`ASSERT_IMPL(a_done_when_idle, clk, arst_n, done, !busy)
	`ASSERT_NEXT(a_query_goes_busy, clk, arst_n, start && !busy && func == FUNC_QUERY, busy)
	`ASSERT_IMPL(a_single_writer, clk, arst_n, 1'b1, $onehot0({cmd.clr_wr, cmd.leaf_wr, cmd.par_wr}))

endmodule

// ----- src/rmt_dp.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rmt_dp
	import rmt_pkg::*;
#(
	parameter int LEAVES      = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rmt_cmd_t          cmd,
	input  logic [IDX_W-1:0]  write_index,
	input  logic [DATA_W-1:0] write_value,
	input  logic [IDX_W-1:0]  query_low,
	input  logic [IDX_W-1:0]  query_high,
	output rmt_sts_t          sts,
	output logic [DATA_W-1:0] range_min,
	output logic              is_infinite
);

	localparam int DEPTH  = 2 * LEAVES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int NODE_W = ADDR_W + 1;
	localparam int CW     = ((NODE_W > IDX_W) ? NODE_W : IDX_W) + 1;

	logic [NODE_W-1:0]      l_q, r_q;
	logic [VALUE_WIDTH-1:0] acc_q;
	logic                   pend_q;
	logic [ADDR_W-1:0]      clr_q;

	logic [CW-1:0]          leaves_w, widx_w, qlo_w, qhi_w, qhi_c;
	logic                   empty;
	logic [NODE_W-1:0]      leaf_node, l0, r0;
	logic [VALUE_WIDTH-1:0] rd_data, merged;
	logic                   we, re;
	logic [ADDR_W-1:0]      waddr, raddr;
	logic [VALUE_WIDTH-1:0] wdata;

	// Request decode: leaf position, clamped query bounds.
	assign leaves_w  = CW'(LEAVES);
	assign widx_w    = CW'(write_index);
	assign qlo_w     = CW'(query_low);
	assign qhi_w     = CW'(query_high);
	assign qhi_c     = (qhi_w >= leaves_w) ? (leaves_w - CW'(1)) : qhi_w;
	assign empty     = (qlo_w > qhi_c);
	assign leaf_node = NODE_W'(widx_w + leaves_w);
	assign l0        = NODE_W'(qlo_w + leaves_w);
	assign r0        = NODE_W'(qhi_c + leaves_w + CW'(1));

	assign merged = (rd_data < acc_q) ? rd_data : acc_q;

	always_comb begin
		we    = cmd.clr_wr | cmd.leaf_wr | cmd.par_wr;
		waddr = l_q[ADDR_W-1:0];
		wdata = acc_q;
		if (cmd.clr_wr) begin
			waddr = clr_q;
			wdata = '1;
		end else if (cmd.par_wr) begin
			waddr = l_q[ADDR_W:1];
			wdata = merged;
		end
	end

	always_comb begin
		re    = cmd.sib_rd | cmd.l_rd | cmd.r_rd;
		raddr = l_q[ADDR_W-1:0];
		if (cmd.sib_rd) begin
			raddr = l_q[ADDR_W-1:0] ^ ADDR_W'(1);
		end else if (cmd.r_rd) begin
			raddr = {r_q[ADDR_W-1:1], 1'b0};
		end
	end

	rmt_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			clr_q  <= '0;
		end else begin
			pend_q <= re;
			if (cmd.clr_wr) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_wr) begin
			l_q   <= leaf_node;
			acc_q <= VALUE_WIDTH'(write_value);
		end else if (cmd.ld_qry) begin
			l_q   <= l0;
			r_q   <= empty ? l0 : r0;
			acc_q <= '1;
		end else begin
			if (pend_q) begin
				acc_q <= merged;
			end
			if (cmd.l_rd) begin
				l_q <= l_q + NODE_W'(1);
			end
			if (cmd.shift) begin
				l_q <= l_q >> 1;
				r_q <= r_q >> 1;
			end
		end
	end

	assign sts.wr_oob   = (widx_w >= leaves_w);
	assign sts.clr_last = (clr_q == ADDR_W'(DEPTH - 1));
	assign sts.par_root = ((l_q >> 1) == NODE_W'(1));
	assign sts.l_lt_r   = (l_q < r_q);
	assign sts.l_odd    = l_q[0];
	assign sts.r_odd    = r_q[0];

	assign range_min   = DATA_W'(acc_q);
	assign is_infinite = (acc_q == '1);

	`ASSERT_IMPL(a_parent_uses_read, clk, arst_n, cmd.par_wr, pend_q)
	`ASSERT_IMPL(a_left_read_in_range, clk, arst_n, cmd.l_rd, l_q < r_q)

endmodule

// ----- src/range_minimum_tree.sv -----
`timescale 1ns / 1ps
// Write request: busy for a leaf write, then per level a sibling read and parent write; one RAM access each.
// Query request: busy while both bounds climb toward the root, two steps per level.
// The query result appears with done for one cycle as busy falls; the receiver cannot stall it.
// Throughput is one request at a time; a new request may start in the cycle done is shown.
// Reset is asynchronous, active low; afterward a clearing pass over all 2*LEAVES nodes keeps busy high.
module range_minimum_tree
	import rmt_pkg::*;
#(
	parameter int LEAVES      = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              func,
	input  logic [IDX_W-1:0]  write_index,
	input  logic [DATA_W-1:0] write_value,
	input  logic [IDX_W-1:0]  query_low,
	input  logic [IDX_W-1:0]  query_high,
	output logic              done,
	output logic [DATA_W-1:0] range_min,
	output logic              is_infinite
);

	// The tree lives in one single-port-write, single-port-read RAM of
	// 2*LEAVES nodes laid out bottom-up: leaf i is node LEAVES+i and node p
	// has the children 2p and 2p+1. The root is node 1 and node 0 is unused.
	//
	// A write request stores the value at its leaf and then climbs toward
	// the root. At each level the sibling is read, and in the cycle after, the
	// minimum of the sibling and the running value is written to the parent.
	// A write whose leaf lies past the end is accepted and dropped.
	//
	// A query request walks two bounds upward. A left bound on a right
	// child and a right bound on a right child each contribute one node,
	// read from the RAM and merged into the accumulator the cycle after.
	// An empty or inverted range leaves the accumulator at all ones, which
	// is the infinity sentinel, and is_infinite flags that value.

	rmt_cmd_t cmd;
	rmt_sts_t sts;

	rmt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.func  (func),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	rmt_dp #(
		.LEAVES     (LEAVES),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.write_index(write_index),
		.write_value(write_value),
		.query_low  (query_low),
		.query_high (query_high),
		.sts        (sts),
		.range_min  (range_min),
		.is_infinite(is_infinite)
	);

endmodule

// ----- dv/range_minimum_tree_checker.sv -----
`timescale 1ns / 1ps
module range_minimum_tree_checker
	import rmt_pkg::*;
#(
	parameter int LEAVES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              func,
	input  logic [IDX_W-1:0]  write_index,
	input  logic [DATA_W-1:0] write_value,
	input  logic [IDX_W-1:0]  query_low,
	input  logic [IDX_W-1:0]  query_high,
	input  logic              done,
	input  logic [DATA_W-1:0] range_min,
	input  logic              is_infinite,
	output int                mismatches,
	output int                outstanding
);

	localparam logic [DATA_W-1:0] INFINITY = '1;

	typedef struct packed {
		logic [DATA_W-1:0] range_min;
		logic              is_infinite;
	} query_answer_t;

	// Shadow copy of the tree: leaf i lives at node LEAVES + i, node p has children 2p and 2p+1.
	logic [DATA_W-1:0] node_min [2*LEAVES];
	query_answer_t     answer_q [$];
	int                failures;

	function automatic void store_leaf(int unsigned leaf, logic [DATA_W-1:0] value);
		int unsigned node;
		if (leaf >= LEAVES)
			return;
		node = leaf + LEAVES;
		node_min[node] = value;
		for (node = node >> 1; node >= 1; node = node >> 1) begin
			node_min[node] = (node_min[2*node] < node_min[2*node+1]) ?
				node_min[2*node] : node_min[2*node+1];
		end
	endfunction

	function automatic query_answer_t range_minimum(int unsigned lo, int unsigned hi);
		logic [DATA_W-1:0] best;
		int unsigned       l;
		int unsigned       r;
		query_answer_t     answer;
		best = INFINITY;
		if (hi >= LEAVES)
			hi = LEAVES - 1;
		if (lo <= hi) begin
			l = lo + LEAVES;
			r = hi + LEAVES + 1;
			while (l < r) begin
				if ((l & 1) != 0) begin
					if (node_min[l] < best)
						best = node_min[l];
					l++;
				end
				if ((r & 1) != 0) begin
					r--;
					if (node_min[r] < best)
						best = node_min[r];
				end
				l = l >> 1;
				r = r >> 1;
			end
		end
		answer.range_min   = best;
		answer.is_infinite = (best == INFINITY);
		return answer;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		query_answer_t want;
		if (!arst_n) begin
			foreach (node_min[n])
				node_min[n] = INFINITY;
			answer_q.delete();
			failures = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			// A result leaves before a new request can add one, so compare first.
			if (done) begin
				if (answer_q.size() == 0) begin
					if (failures < 10)
						$display("%0t: unexpected result range_min=%h is_infinite=%b",
							$realtime, range_min, is_infinite);
					failures++;
				end else begin
					want = answer_q.pop_front();
					if (range_min !== want.range_min || is_infinite !== want.is_infinite) begin
						if (failures < 10)
							$display("%0t: range_min exp %h got %h, is_infinite exp %b got %b",
								$realtime, want.range_min, range_min,
								want.is_infinite, is_infinite);
						failures++;
					end
				end
			end
			if (start && !busy) begin
				if (func == FUNC_WRITE)
					store_leaf(write_index, write_value);
				else
					answer_q.insert(answer_q.size(), range_minimum(query_low, query_high));
			end
			mismatches <= failures;
			outstanding <= answer_q.size();
		end
	end

endmodule

// ----- dv/range_minimum_tree_test.sv -----
`timescale 1ns / 1ps
// Top of the range minimum tree bench. This module only generates requests and
// gives the verdict; the checker beside the block keeps a shadow tree, predicts
// every query answer and compares it with what the block reports.
module range_minimum_tree_test;
	import rmt_pkg::*;

	localparam int LEAVES           = 1024;
	// Random requests in each of the three idling phases.
	localparam int RANDOM_PER_PHASE = 400;
	// Settling time at the end of the run; it covers anything still in flight.
	localparam int SETTLE_CYCLES    = 30;
	// The clearing pass after reset runs without a handshake, and both it and the
	// longest sender gaps stay far below this.
	localparam int WATCHDOG_LIMIT   = 10000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              func;
	logic [IDX_W-1:0]  write_index;
	logic [DATA_W-1:0] write_value;
	logic [IDX_W-1:0]  query_low;
	logic [IDX_W-1:0]  query_high;
	logic              done;
	logic [DATA_W-1:0] range_min;
	logic              is_infinite;

	int mismatches;
	int outstanding;
	int idle_percent;
	int quiet_cycles = 0;

	// 4 ns clock period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	range_minimum_tree #(
		.LEAVES      (LEAVES),
		.VALUE_WIDTH (DATA_W)
	) i_dut (.*);

	range_minimum_tree_checker #(
		.LEAVES (LEAVES)
	) i_checker (.*);

	// The watchdog counts cycles in which neither a request nor a result
	// is accepted. A hung block ends the run here.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Presents one request and returns at the edge that accepts it. Before the
	// request, start may drop for a random number of cycles, set by idle_percent.
	// When there is no gap, start simply stays high into the next request.
	task automatic send_request(logic f, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value,
			logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_percent)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		write_index <= idx;
		write_value <= value;
		query_low <= lo;
		query_high <= hi;
		// busy read right after the edge is still the value that edge saw.
		do @(posedge clk); while (busy);
	endtask

	// Holds off new requests until every query answer has come back. The first
	// edge is always taken so that a query accepted just now is counted.
	task automatic wait_for_answers();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// One random request. Writes go partly to two hot regions at the ends of the
	// leaf row so that narrow queries there find finite values, and values lean
	// toward zero, small numbers and the infinity pattern. The fields that the
	// chosen function ignores still carry random data.
	task automatic random_request();
		logic              f;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] value;
		logic [IDX_W-1:0]  lo;
		logic [IDX_W-1:0]  hi;
		int                upper;
		f = ($urandom_range(99) < 45) ? FUNC_WRITE : FUNC_QUERY;
		case ($urandom_range(3))
			0: idx = IDX_W'($urandom_range(15));
			1: idx = IDX_W'(LEAVES - 1 - int'($urandom_range(15)));
			default: idx = IDX_W'($urandom_range(LEAVES - 1));
		endcase
		case ($urandom_range(9))
			0: value = '1;
			1: value = '0;
			2: value = DATA_W'($urandom_range(255));
			default: value = $urandom;
		endcase
		case ($urandom_range(5))
			0: begin
				// Nearly the whole row.
				lo = IDX_W'($urandom_range(3));
				hi = IDX_W'(LEAVES - 1 - int'($urandom_range(3)));
			end
			1: begin
				// Inverted range, always empty.
				lo = IDX_W'($urandom_range(LEAVES - 1, 1));
				hi = IDX_W'($urandom_range(int'(lo) - 1, 0));
			end
			2: begin
				lo = IDX_W'($urandom_range(LEAVES - 1));
				hi = lo;
			end
			3: begin
				lo = IDX_W'($urandom_range(LEAVES - 1));
				upper = int'(lo) + int'($urandom_range(63));
				hi = (upper > LEAVES - 1) ? IDX_W'(LEAVES - 1) : IDX_W'(upper);
			end
			default: begin
				lo = IDX_W'($urandom_range(LEAVES - 1));
				hi = IDX_W'($urandom_range(LEAVES - 1));
			end
		endcase
		send_request(f, idx, value, lo, hi);
	endtask

	initial begin
		int phase;
		arst_n <= 1'b0;
		start <= 1'b0;
		func <= FUNC_WRITE;
		write_index <= '0;
		write_value <= '0;
		query_low <= '0;
		query_high <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests, sent with the first phase's idling. The block is
		// busy with its clearing pass at first; the handshake simply waits.
		idle_percent = 13;
		// A freshly cleared tree answers infinity everywhere.
		send_request(FUNC_QUERY, '0, '0, '0, IDX_W'(LEAVES - 1));
		// Extremes of the leaf row and of the value range.
		send_request(FUNC_WRITE, '0, '0, '1, '0);
		send_request(FUNC_WRITE, IDX_W'(LEAVES - 1), 32'hFFFF_FFFE, '0, '1);
		// Writing all ones stores infinity, as if never written.
		send_request(FUNC_WRITE, IDX_W'(512), '1, '0, '0);
		send_request(FUNC_QUERY, '1, '1, '0, IDX_W'(LEAVES - 1));
		send_request(FUNC_QUERY, '0, '0, IDX_W'(LEAVES - 1), IDX_W'(LEAVES - 1));
		send_request(FUNC_QUERY, '0, '0, '0, '0);
		// Inverted ranges are empty.
		send_request(FUNC_QUERY, '0, '0, IDX_W'(5), IDX_W'(3));
		send_request(FUNC_QUERY, '0, '0, IDX_W'(LEAVES - 1), '0);
		// Only the infinity leaf lies inside.
		send_request(FUNC_QUERY, '0, '0, IDX_W'(1), IDX_W'(LEAVES - 2));
		send_request(FUNC_WRITE, IDX_W'(1), 32'h8000_0000, '0, '0);
		send_request(FUNC_QUERY, '0, '0, IDX_W'(1), IDX_W'(LEAVES - 2));
		// Overwriting a finite leaf with infinity removes it again.
		send_request(FUNC_WRITE, '0, '1, '0, '0);
		send_request(FUNC_QUERY, '0, '0, '0, '0);
		send_request(FUNC_QUERY, '0, '0, '0, IDX_W'(LEAVES - 1));
		send_request(FUNC_WRITE, IDX_W'(LEAVES - 1), '0, '0, '0);
		send_request(FUNC_QUERY, '0, '0, IDX_W'(LEAVES - 1), IDX_W'(LEAVES - 1));
		send_request(FUNC_QUERY, '0, '0, IDX_W'(512), IDX_W'(512));
		send_request(FUNC_QUERY, '1, '1, IDX_W'(2), IDX_W'(LEAVES - 2));

		// Random phases: moderate sender idling, heavy idling, then back to back.
		// Each phase ends with a pause until all answers are in.
		for (phase = 0; phase < 3; phase++) begin
			idle_percent = (phase == 0) ? 13 : (phase == 1) ? 64 : 0;
			repeat (RANDOM_PER_PHASE) random_request();
			wait_for_answers();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- range_minimum_tree.f -----
+incdir+src
src/rmt_pkg.sv
src/rmt_ram.sv
src/rmt_ctrl.sv
src/rmt_dp.sv
src/range_minimum_tree.sv
dv/range_minimum_tree_checker.sv
dv/range_minimum_tree_test.sv
